// ----- src/lef_pkg.sv -----
// Shared types, widths and codes of the RGB Laplacian edge filter.
`default_nettype none
package lef_pkg;

  // Field widths that the stream format fixes.
  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 3 * CHAN_W;
  localparam int COORD_W      = 10;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 8;
  localparam int OUT_FIELDS_W = PIX_W + 2 * COORD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Accumulator for eight times a channel minus eight neighbours.
  localparam int ACC_W = CHAN_W + 5;
  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // Size limits and the size registers' value after reset.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int CFG_RESET      = 1024;

  // Depth of the queue between the front and back parts (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indices.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_IN_USE  = CFG_IDX_W'(0),
    REG_HEIGHT_IN_USE = CFG_IDX_W'(1)
  } reg_index_t;

  // One item passed from the front part to the back part: the new window
  // column and what the back part must do with it.
  typedef struct packed {
    logic [PIX_W-1:0]   up;
    logic [PIX_W-1:0]   mid;
    logic [PIX_W-1:0]   px;
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] ccol;
    logic [COORD_W-1:0] crow;
  } entry_t;

  // One column of the 3x3 window, top to bottom.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

endpackage
`default_nettype wire

// ----- src/rgb_laplacian_edge_filter_top.sv -----
// Top level of the streaming RGB 3x3 Laplacian edge filter.
//
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data (size registers)
// s        in         s_tvalid/s_tready    s_tdata pixel, s_tuser frame start
// m        out        m_tvalid/m_tready    m_tdata edge result, m_tlast frame last
//
// One pixel is taken every clock while s_tready is high; a result passes
// through stage one, the queue and the output register. The line store RAM
// is read once and written once per pixel. Reset clears the position counters,
// window, queue and handshake state; the line stores are not cleared. A stall
// on the output fills the four-entry queue before s_tready falls.
`default_nettype none
module rgb_laplacian_edge_filter_top #(
  parameter int MAX_WIDTH  = lef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lef_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lef_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [lef_pkg::PIX_W-1:0]      s_tdata,   // pixel_red, pixel_green, pixel_blue
  input  wire logic                           s_tuser,   // frame_start
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [lef_pkg::OUT_DATA_W-1:0]      m_tdata,   // edge_red, edge_green, edge_blue,
                                                         // center_column, center_row, zero pad
  output logic                                m_tlast    // frame_last
);
  import lef_pkg::*;

  logic   q_push;
  logic   q_ready;
  logic   q_pop;
  logic   q_valid;
  entry_t q_in;
  entry_t q_head;

  // Front part: position, line stores and classification.
  lef_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (q_push),
    .push_data (q_in),
    .q_ready   (q_ready)
  );

  // Queue decoupling the two parts.
  lef_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back part: window, arithmetic and output register.
  lef_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // A result only appears after an item was taken from the queue.
  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_pop))
    else $error("result appeared without a queue item");

  // The front part never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("push into full queue");

  // The back part never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");
`endif

endmodule
`default_nettype wire

// ----- src/lef_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module lef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a read at the address being written returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/lef_front.sv -----
// Front part: size registers, pixel position tracking, line stores and classification.
`default_nettype none
module lef_front #(
  parameter int MAX_WIDTH  = lef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lef_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lef_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [lef_pkg::PIX_W-1:0]      s_tdata,
  input  wire logic                           s_tuser,
  output logic                                push,
  output lef_pkg::entry_t                     push_data,
  input  wire logic                           q_ready
);
  import lef_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WW     = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HW     = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int W_RST  = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
  localparam int H_RST  = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;
  localparam int LINE_W = 2 * PIX_W;

  logic [WW-1:0]     wlim;
  logic [HW-1:0]     hlim;
  logic [WW-1:0]     wcfg;
  logic [HW-1:0]     hcfg;
  logic [WW-1:0]     wcfg_sat;
  logic [HW-1:0]     hcfg_sat;
  logic [CW-1:0]     col_cnt;
  logic [RW-1:0]     row_cnt;
  logic [CW-1:0]     col_cur;
  logic [RW-1:0]     row_cur;
  logic [WW-1:0]     col_x;
  logic [HW-1:0]     row_x;
  logic              in_frame;
  logic              is_last;
  logic              col_wrap;
  logic              row_wrap;
  logic              accept;
  logic              advance;
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_px;
  logic [CW-1:0]     s1_idx;
  logic              s1_emit;
  logic              s1_last;
  logic [COORD_W-1:0] s1_ccol;
  logic [COORD_W-1:0] s1_crow;
  logic              s1_fwd;
  logic [LINE_W-1:0] s1_fwd_data;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_q;
  logic [PIX_W-1:0]  line_up;
  logic [PIX_W-1:0]  line_mid;

  // Size registers hold the saturated size, so the data path never sees
  // a value outside three to the maximum.
  assign cfg_ready = 1'b1;
  assign wcfg = WW'(cfg_data);
  assign hcfg = HW'(cfg_data);
  assign wcfg_sat = (wcfg < WW'(3)) ? WW'(3) :
                    (wcfg > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : wcfg;
  assign hcfg_sat = (hcfg < HW'(3)) ? HW'(3) :
                    (hcfg > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : hcfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlim <= WW'(W_RST);
      hlim <= HW'(H_RST);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WIDTH_IN_USE) begin
        wlim <= wcfg_sat;
      end
      if (cfg_index == REG_HEIGHT_IN_USE) begin
        hlim <= hcfg_sat;
      end
    end
  end

  // Handshake: stage one moves on whenever the queue has room.
  assign advance  = s1_valid && q_ready;
  assign s_tready = !s1_valid || q_ready;
  assign accept   = s_tvalid && s_tready;

  // Position of the arriving pixel; frame start puts it at the origin.
  assign col_cur  = s_tuser ? '0 : col_cnt;
  assign row_cur  = s_tuser ? '0 : row_cnt;
  assign col_x    = WW'(col_cur);
  assign row_x    = HW'(row_cur);
  assign in_frame = (col_x >= WW'(2)) && (row_x >= HW'(2)) && (col_x < wlim) && (row_x < hlim);
  assign is_last  = (col_x == wlim - WW'(1)) && (row_x == hlim - HW'(1));
  assign col_wrap = (col_x + WW'(1)) >= wlim;
  assign row_wrap = (row_x + HW'(1)) >= hlim;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_cur + RW'(1);
      end else begin
        col_cnt <= col_cur + CW'(1);
        row_cnt <= row_cur;
      end
    end
  end

  // Stage one valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload; a read of the entry being written this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= s_tdata;
      s1_idx      <= col_cur;
      s1_emit     <= in_frame;
      s1_last     <= is_last;
      s1_ccol     <= COORD_W'(col_cur - CW'(1));
      s1_crow     <= COORD_W'(row_cur - RW'(1));
      s1_fwd      <= advance && (s1_idx == col_cur);
      s1_fwd_data <= {line_mid, s1_px};
    end
  end

  // Both line stores share one word: upper row in the high half.
  lef_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_idx),
    .wdata ({line_mid, s1_px}),
    .re    (accept),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  assign line_q   = s1_fwd ? s1_fwd_data : ram_rdata;
  assign line_up  = line_q[LINE_W-1:PIX_W];
  assign line_mid = line_q[PIX_W-1:0];

  // Item handed to the queue.
  assign push = advance;
  always_comb begin
    push_data.up   = line_up;
    push_data.mid  = line_mid;
    push_data.px   = s1_px;
    push_data.emit = s1_emit;
    push_data.last = s1_last;
    push_data.ccol = s1_ccol;
    push_data.crow = s1_crow;
  end

endmodule
`default_nettype wire

// ----- src/lef_queue.sv -----
// Short first-in first-out queue of window columns between front and back parts.
`default_nettype none
module lef_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire lef_pkg::entry_t push_data,
  output logic           ready,
  input  wire logic      pop,
  output logic           valid,
  output lef_pkg::entry_t head
);
  import lef_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign ready   = count != (PW + 1)'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign head    = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- src/lef_back.sv -----
// Back part: 3x3 window, Laplacian per colour with clamping, and output register.
`default_nettype none
module lef_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire lef_pkg::entry_t               head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lef_pkg::OUT_DATA_W-1:0]     m_tdata,  // edge_red, edge_green, edge_blue,
                                                       // center_column, center_row, zero pad
  output logic                               m_tlast   // frame_last
);
  import lef_pkg::*;

  localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;

  column_t            win_a;
  column_t            win_b;
  column_t            win_c;
  logic [PIX_W-1:0]   edge_pix;
  logic [PIX_W-1:0]   out_edge;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               out_last;

  // Eight times the centre minus the eight neighbours, clamped to a byte.
  function automatic logic [CHAN_W-1:0] laplace_chan(
    input logic [CHAN_W-1:0]   ctr,
    input logic [8*CHAN_W-1:0] nb
  );
    logic [ACC_W-1:0] nsum;
    logic [ACC_W-1:0] diff;
    nsum = '0;
    for (int k = 0; k < 8; k++) begin
      nsum = nsum + ACC_W'(nb[k*CHAN_W +: CHAN_W]);
    end
    diff = (ACC_W'(ctr) << 3) - nsum;
    if (diff[ACC_W-1]) begin
      return '0;
    end else if (diff > ACC_W'(CHAN_MAX)) begin
      return CHAN_MAX;
    end else begin
      return diff[CHAN_W-1:0];
    end
  endfunction

  // The newest column comes from the queue head.
  always_comb begin
    win_c.top = head.up;
    win_c.mid = head.mid;
    win_c.bot = head.px;
  end

  // One Laplacian per colour; the centre is the middle of the previous column.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      edge_pix[ch*CHAN_W +: CHAN_W] = laplace_chan(
        win_b.mid[ch*CHAN_W +: CHAN_W],
        {win_a.top[ch*CHAN_W +: CHAN_W], win_a.mid[ch*CHAN_W +: CHAN_W],
         win_a.bot[ch*CHAN_W +: CHAN_W], win_b.top[ch*CHAN_W +: CHAN_W],
         win_b.bot[ch*CHAN_W +: CHAN_W], win_c.top[ch*CHAN_W +: CHAN_W],
         win_c.mid[ch*CHAN_W +: CHAN_W], win_c.bot[ch*CHAN_W +: CHAN_W]});
    end
  end

  // Every item moves the window; only items with a result need the output free.
  assign pop = q_valid && (!m_tvalid || m_tready || !head.emit);

  // Window columns shift on every item taken from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_b <= '0;
    end else if (pop) begin
      win_a <= win_b;
      win_b <= win_c;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && head.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop && head.emit) begin
      out_edge <= edge_pix;
      out_col  <= head.ccol;
      out_row  <= head.crow;
      out_last <= head.last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_row, out_col, out_edge};
  assign m_tlast = out_last;

endmodule
`default_nettype wire
